@@ rtl/omd_pkg.sv @@
// ----------------------------------------------------------------------------
// omd_pkg: shared types and constants for the optical Morse decoder
// Result codes, register map, control structs and the Morse code table.
// ----------------------------------------------------------------------------
package omd_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_LETTER  = 2'd0,
    KIND_SPACE   = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  // register map, word index
  typedef enum logic [2:0] {
    REG_LIGHT_THR   = 3'd0,
    REG_DOT_MIN     = 3'd1,
    REG_DOT_MAX     = 3'd2,
    REG_DASH_MAX    = 3'd3,
    REG_LETTER_MIN  = 3'd4,
    REG_LETTER_LIM  = 3'd5,
    REG_WORD_GAP    = 3'd6,
    REG_MESSAGE_GAP = 3'd7
  } reg_idx_t;

  localparam int CFG_ADDR_BITS = 5;
  localparam int THR_BITS      = 12;
  localparam int RUN_BITS      = 8;

  // register reset values
  localparam logic [THR_BITS-1:0] RST_LIGHT_THR   = 12'd21;
  localparam logic [RUN_BITS-1:0] RST_DOT_MIN     = 8'd2;
  localparam logic [RUN_BITS-1:0] RST_DOT_MAX     = 8'd4;
  localparam logic [RUN_BITS-1:0] RST_DASH_MAX    = 8'd7;
  localparam logic [RUN_BITS-1:0] RST_LETTER_MIN  = 8'd8;
  localparam logic [RUN_BITS-1:0] RST_LETTER_LIM  = 8'd11;
  localparam logic [RUN_BITS-1:0] RST_WORD_GAP    = 8'd14;
  localparam logic [RUN_BITS-1:0] RST_MESSAGE_GAP = 8'd33;

  // result buffer geometry
  localparam int RB_DEPTH    = 8;
  localparam int RB_PTR_BITS = 3;
  localparam int RB_CNT_BITS = 4;

  typedef struct packed {
    logic [THR_BITS-1:0] light_threshold;
    logic [RUN_BITS-1:0] dot_min;
    logic [RUN_BITS-1:0] dot_max;
    logic [RUN_BITS-1:0] dash_max;
    logic [RUN_BITS-1:0] letter_gap_min;
    logic [RUN_BITS-1:0] letter_gap_limit;
    logic [RUN_BITS-1:0] word_gap;
    logic [RUN_BITS-1:0] message_gap;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] char_code;
    logic       last;
  } result_t;

  // up to two results per sample, packed from res0
  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t res0;
    result_t res1;
  } push_t;

  // Morse table: length, pattern (bit i set when symbol i is a dash), ASCII
  localparam int MORSE_ENTRIES = 36;

  localparam logic [2:0] MORSE_LEN [MORSE_ENTRIES] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [4:0] MORSE_PAT [MORSE_ENTRIES] = '{
    5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, // A B C D E
    5'b00100, 5'b00011, 5'b00000, 5'b00000, 5'b01110, // F G H I J
    5'b00101, 5'b00010, 5'b00011, 5'b00001, 5'b00111, // K L M N O
    5'b00110, 5'b01011, 5'b00010, 5'b00000, 5'b00001, // P Q R S T
    5'b00100, 5'b01000, 5'b00110, 5'b01001, 5'b01101, // U V W X Y
    5'b00011,                                         // Z
    5'b11110, 5'b11100, 5'b11000, 5'b10000, 5'b00000, // 1 2 3 4 5
    5'b00001, 5'b00011, 5'b00111, 5'b01111, 5'b11111  // 6 7 8 9 0
  };

  localparam logic [6:0] MORSE_CHR [MORSE_ENTRIES] = '{
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A,
    7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54,
    7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
  };

  // returns the ASCII code for the held symbols, zero when nothing matches
  function automatic logic [6:0] morse_lookup(input logic [7:0] bits,
                                               input logic [3:0] cnt);
    logic [6:0] ch;
    ch = '0;
    for (int e = 0; e < MORSE_ENTRIES; e++) begin
      if (cnt == 4'(MORSE_LEN[e]) && bits == 8'(MORSE_PAT[e])) begin
        ch = MORSE_CHR[e];
      end
    end
    return ch;
  endfunction

endpackage

@@ rtl/optical_morse_decoder.sv @@
// ----------------------------------------------------------------------------
// optical_morse_decoder: light-sensor Morse decoder
// Thresholds one sample per beat, times light pulses and gaps, and emits
// letters, word spaces, invalid-code and end-of-message markers.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_sample
//   out_     output     out_valid/out_stall  out_kind, out_char_code, out_last
//   cfg      input      psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// A sample is registered on acceptance, decoded in the next cycle and its
// results land in an 8-beat result buffer, one sample per cycle while in_stall
// is low. The output drains one beat per cycle while out_stall is low, so a
// sample with two results (letter and word space) takes two output beats;
// in_stall rises when the buffer cannot hold the pending sample's results and two more.
// Reset is synchronous; registers return to their defaults and the
// buffer empties.
// ----------------------------------------------------------------------------
module optical_morse_decoder
  import omd_pkg::*;
#(
  parameter int MAX_SYMBOLS = 6,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // sample channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_BITS-1:0]   in_sample,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_kind,
  output logic [6:0]               out_char_code,
  output logic                     out_last,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  cfg_t                   cfg_r;
  logic                   in_vld_r;
  logic [SAMPLE_BITS-1:0] in_sample_r;
  logic                   in_acc, reg_wr;
  reg_idx_t               reg_idx;
  push_t                  push;
  result_t                res;

  // register port
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_threshold  <= RST_LIGHT_THR;
      cfg_r.dot_min          <= RST_DOT_MIN;
      cfg_r.dot_max          <= RST_DOT_MAX;
      cfg_r.dash_max         <= RST_DASH_MAX;
      cfg_r.letter_gap_min   <= RST_LETTER_MIN;
      cfg_r.letter_gap_limit <= RST_LETTER_LIM;
      cfg_r.word_gap         <= RST_WORD_GAP;
      cfg_r.message_gap      <= RST_MESSAGE_GAP;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_LIGHT_THR:   cfg_r.light_threshold  <= pwdata[THR_BITS-1:0];
        REG_DOT_MIN:     cfg_r.dot_min          <= pwdata[RUN_BITS-1:0];
        REG_DOT_MAX:     cfg_r.dot_max          <= pwdata[RUN_BITS-1:0];
        REG_DASH_MAX:    cfg_r.dash_max         <= pwdata[RUN_BITS-1:0];
        REG_LETTER_MIN:  cfg_r.letter_gap_min   <= pwdata[RUN_BITS-1:0];
        REG_LETTER_LIM:  cfg_r.letter_gap_limit <= pwdata[RUN_BITS-1:0];
        REG_WORD_GAP:    cfg_r.word_gap         <= pwdata[RUN_BITS-1:0];
        REG_MESSAGE_GAP: cfg_r.message_gap      <= pwdata[RUN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LIGHT_THR:   prdata = 32'(cfg_r.light_threshold);
      REG_DOT_MIN:     prdata = 32'(cfg_r.dot_min);
      REG_DOT_MAX:     prdata = 32'(cfg_r.dot_max);
      REG_DASH_MAX:    prdata = 32'(cfg_r.dash_max);
      REG_LETTER_MIN:  prdata = 32'(cfg_r.letter_gap_min);
      REG_LETTER_LIM:  prdata = 32'(cfg_r.letter_gap_limit);
      REG_WORD_GAP:    prdata = 32'(cfg_r.word_gap);
      REG_MESSAGE_GAP: prdata = 32'(cfg_r.message_gap);
      default:         prdata = '0;
    endcase
  end

  // input register
  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_sample_r <= in_sample;
    end
  end

  // decode step
  omd_core #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_vld_r),
    .sample (in_sample_r),
    .cfg    (cfg_r),
    .push   (push)
  );

  // result buffer
  omd_rbuf u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pend      (in_vld_r),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_kind      = res.kind;
  assign out_char_code = res.char_code;
  assign out_last      = res.last;

endmodule

@@ rtl/omd_core.sv @@
// ----------------------------------------------------------------------------
// omd_core: per-sample Morse decode step
// Holds the run counters and symbol store, classifies pulses and gaps and
// forms up to two results for each registered sample.
// ----------------------------------------------------------------------------
module omd_core
  import omd_pkg::*;
#(
  parameter int MAX_SYMBOLS = 6,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  cfg_t                   cfg,
  output push_t                  push
);

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int CMP_W = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

  logic [RUN_BITS-1:0]    high_run_r, high_run_nxt;
  logic [RUN_BITS-1:0]    low_run_r, low_run_nxt;
  logic                   guard_r, guard_nxt;
  logic                   word_armed_r, word_armed_nxt;
  logic                   msg_armed_r, msg_armed_nxt;
  logic [MAX_SYMBOLS-1:0] sym_bits_r, sym_bits_nxt;
  logic [CNT_W-1:0]       sym_cnt_r, sym_cnt_nxt;

  logic                   light, low_nz, letter_end;
  logic                   is_dot, is_dash, add_ok;
  logic [MAX_SYMBOLS-1:0] add_bits;
  logic [CNT_W-1:0]       add_cnt;
  logic                   word_hit, msg_hit;
  logic [RUN_BITS-1:0]    high_inc, low_inc;
  logic [6:0]             lk_char;
  result_t                lk_res, space_res, end_res;

  // sample and run classification
  assign light      = CMP_W'(sample) > CMP_W'(cfg.light_threshold);
  assign low_nz     = low_run_r != '0;
  assign letter_end = light && low_nz && !guard_r &&
                      low_run_r >= cfg.letter_gap_min &&
                      low_run_r <  cfg.letter_gap_limit;
  assign is_dot     = high_run_r >= cfg.dot_min && high_run_r <= cfg.dot_max;
  assign is_dash    = !is_dot && high_run_r > cfg.dot_max &&
                      high_run_r <= cfg.dash_max;
  assign add_ok     = (is_dot || is_dash) && sym_cnt_r < CNT_W'(MAX_SYMBOLS);
  assign word_hit   = !light && low_run_r == cfg.word_gap;
  assign msg_hit    = !light && !word_hit && low_run_r == cfg.message_gap;
  assign high_inc   = (high_run_r == '1) ? high_run_r : high_run_r + 8'd1;
  assign low_inc    = (low_run_r == '1) ? low_run_r : low_run_r + 8'd1;

  // symbol store with the pulse that just ended appended
  always_comb begin
    add_bits = sym_bits_r;
    add_cnt  = sym_cnt_r;
    if (add_ok) begin
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        if (CNT_W'(i) == sym_cnt_r) begin
          add_bits[i] = is_dash;
        end
      end
      add_cnt = sym_cnt_r + CNT_W'(1);
    end
  end

  // one table lookup: held symbols at a rising edge, updated ones in a gap
  assign lk_char = light ? morse_lookup(8'(sym_bits_r), 4'(sym_cnt_r))
                         : morse_lookup(8'(add_bits), 4'(add_cnt));

  always_comb begin
    lk_res.kind      = (lk_char != '0) ? KIND_LETTER : KIND_INVALID;
    lk_res.char_code = lk_char;
    lk_res.last      = 1'b1;
    space_res        = '{kind: KIND_SPACE, char_code: '0, last: 1'b1};
    end_res          = '{kind: KIND_END, char_code: '0, last: 1'b1};
  end

  // results for this sample
  always_comb begin
    push      = '0;
    push.res0 = lk_res;
    push.res1 = space_res;
    if (step) begin
      if (letter_end && sym_cnt_r != '0) begin
        push.vld0 = 1'b1;
      end else if (word_hit && word_armed_r) begin
        push.vld0      = 1'b1;
        push.vld1      = 1'b1;
        push.res0.last = 1'b0;
      end else if (msg_hit && msg_armed_r) begin
        push.vld0 = 1'b1;
        push.res0 = end_res;
      end
    end
  end

  // next state
  always_comb begin
    high_run_nxt   = high_run_r;
    low_run_nxt    = low_run_r;
    guard_nxt      = guard_r;
    word_armed_nxt = word_armed_r;
    msg_armed_nxt  = msg_armed_r;
    sym_bits_nxt   = sym_bits_r;
    sym_cnt_nxt    = sym_cnt_r;
    if (light) begin
      if (low_nz) begin
        if (letter_end) begin
          sym_bits_nxt = '0;
          sym_cnt_nxt  = '0;
        end
        if (guard_r) begin
          low_run_nxt = '0;
        end
        guard_nxt = 1'b1;
      end else begin
        guard_nxt = 1'b0;
      end
      high_run_nxt = high_inc;
    end else begin
      guard_nxt    = 1'b0;
      sym_bits_nxt = add_bits;
      sym_cnt_nxt  = add_cnt;
      if (word_hit) begin
        if (word_armed_r) begin
          sym_bits_nxt = '0;
          sym_cnt_nxt  = '0;
        end else begin
          word_armed_nxt = 1'b1;
        end
      end else if (msg_hit) begin
        msg_armed_nxt = 1'b1;
      end
      low_run_nxt  = low_inc;
      high_run_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_run_r   <= '0;
      low_run_r    <= '0;
      guard_r      <= 1'b0;
      word_armed_r <= 1'b0;
      msg_armed_r  <= 1'b0;
      sym_bits_r   <= '0;
      sym_cnt_r    <= '0;
    end else if (step) begin
      high_run_r   <= high_run_nxt;
      low_run_r    <= low_run_nxt;
      guard_r      <= guard_nxt;
      word_armed_r <= word_armed_nxt;
      msg_armed_r  <= msg_armed_nxt;
      sym_bits_r   <= sym_bits_nxt;
      sym_cnt_r    <= sym_cnt_nxt;
    end
  end

endmodule

@@ rtl/omd_rbuf.sv @@
// ----------------------------------------------------------------------------
// omd_rbuf: result buffer
// Small queue: takes up to two result beats per cycle, hands them out one
// per cycle while out_stall is low, and drives in_stall from its fill level.
// ----------------------------------------------------------------------------
module omd_rbuf
  import omd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  logic    pend,      // a sample is registered and will push next edge
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  result_t                mem_r [RB_DEPTH];
  logic [RB_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RB_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RB_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0]             npush;
  logic                   pop;
  logic [RB_CNT_BITS:0]   level;

  assign npush = {1'b0, push.vld0} + {1'b0, push.vld1};
  assign pop   = out_valid && !out_stall;

  // room for the pending sample and one more, two beats each
  assign level    = {1'b0, cnt_r} + {{(RB_CNT_BITS-1){1'b0}}, pend, 1'b0};
  assign in_stall = level > (RB_CNT_BITS+1)'(RB_DEPTH - 2);

  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RB_PTR_BITS'(npush);
    rd_ptr_nxt = pop ? rd_ptr_r + RB_PTR_BITS'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + RB_CNT_BITS'(npush) - RB_CNT_BITS'(pop);
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push.vld0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.vld1) begin
      mem_r[wr_ptr_r + RB_PTR_BITS'(1)] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/omd_checker.sv @@
// ----------------------------------------------------------------------------
// omd_checker: port-level checks for the optical Morse decoder
// Watches the result channel for reset, hold and result-ordering rules.
// ----------------------------------------------------------------------------
module omd_checker
  import omd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [6:0] out_char_code,
  input logic       out_last
);

  // no result beat straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat offered right after reset");

  // a stalled beat stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
                               $stable(out_char_code) && $stable(out_last))
    else $error("stalled result beat changed");

  // only letters carry a character code
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_LETTER |-> out_char_code == 7'd0)
    else $error("non-letter beat carries a character code");

  // the only two-beat sample is a lookup followed by a word space
  a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_kind == KIND_LETTER || out_kind == KIND_INVALID)
    else $error("non-final beat is not a lookup result");

  a_space_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_SPACE || out_kind == KIND_END) |-> out_last)
    else $error("space or end marker not final beat of its sample");

endmodule

bind optical_morse_decoder omd_checker u_omd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_char_code (out_char_code),
  .out_last      (out_last)
);
